@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file rvh_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked at every rising clock edge, masked while reset is high.
`define RVH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rvh assertion failed");
// Checked at every rising clock edge, reset included.
`define RVH_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("rvh assertion failed");
`endif

@@ sv/rvh_pkg.sv @@
// Package: transaction types, opcodes, status codes and CSR constants of the hart.
`default_nettype none
package rvh_pkg;

   typedef struct packed {
      logic        op;
      logic [31:0] load_address;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [31:0] executed_instruction;
      logic [1:0]  status;
      logic        dest_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [2:0]  funct3;
      logic [31:0] a;
      logic [31:0] b;
   } mdu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } mdu_rsp_type;

   localparam logic [1:0] ST_EXEC    = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_ECALL   = 2'd2;
   localparam logic [1:0] ST_LOADED  = 2'd3;

   localparam logic ITEM_STORE = 1'b0;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_FENCE  = 7'h0F;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_ALT    = 7'h20;

   localparam logic [31:0] INSN_ECALL = 32'h0000_0073;
   localparam logic [31:0] INSN_MRET  = 32'h3020_0073;

   localparam int CSR_ENTRIES = 4096;
   localparam int CSR_AW      = $clog2(CSR_ENTRIES);
   localparam logic [11:0] EPC_ADDR    = 12'h341;
   localparam logic [11:0] HARTID_ADDR = 12'hF14;

endpackage
`default_nettype wire

@@ sv/rvh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rvh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire                       clock,
   input  wire                       we,
   input  wire  [$clog2(DEPTH)-1:0]  waddr,
   input  wire  [WIDTH-1:0]          wdata,
   input  wire  [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]          rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ sv/rvh_mdu.sv @@
// Iterative multiply/divide unit: one shift-add or shift-subtract step per cycle.
`default_nettype none
module rvh_mdu import rvh_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  mdu_req_type  req,
   output mdu_rsp_type  rsp
);
   typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mstate_type;

   mstate_type  state_ff, state_in;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in, mag_ff, mag_in, a_ff, a_in;
   logic [2:0]  f3_ff, f3_in;
   logic        na_ff, na_in, nb_ff, nb_in, bz_ff, bz_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [31:0] res_ff, res_in;

   logic        sa, sb, is_div, na, nb;
   logic [31:0] ma, mb;
   logic [32:0] msum, dt;
   logic [33:0] ddiff;
   logic [63:0] prod, prodn;

   always_comb begin
      sa = (req.funct3 == 3'd1) || (req.funct3 == 3'd2) ||
           (req.funct3 == 3'd4) || (req.funct3 == 3'd6);
      sb = (req.funct3 == 3'd1) || (req.funct3 == 3'd4) || (req.funct3 == 3'd6);
      na = sa & req.a[31];
      nb = sb & req.b[31];
      ma = na ? (32'd0 - req.a) : req.a;
      mb = nb ? (32'd0 - req.b) : req.b;
      is_div = f3_ff[2];

      msum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mag_ff} : 33'd0);
      dt    = {hi_ff, lo_ff[31]};
      ddiff = {1'b0, dt} - {2'b00, mag_ff};
      prod  = {hi_ff, lo_ff};
      prodn = (na_ff ^ nb_ff) ? (64'd0 - prod) : prod;

      state_in = state_ff;
      hi_in = hi_ff; lo_in = lo_ff; mag_in = mag_ff; a_in = a_ff;
      f3_in = f3_ff; na_in = na_ff; nb_in = nb_ff; bz_in = bz_ff;
      cnt_in = cnt_ff; res_in = res_ff;
      done_in = 1'b0;

      case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               f3_in  = req.funct3;
               na_in  = na;
               nb_in  = nb;
               bz_in  = (req.b == 32'd0);
               a_in   = req.a;
               hi_in  = 32'd0;
               lo_in  = req.funct3[2] ? ma : mb;
               mag_in = req.funct3[2] ? mb : ma;
               cnt_in = 5'd0;
               state_in = M_RUN;
            end
         end
         M_RUN: begin
            if (is_div) begin
               if (!ddiff[33]) begin
                  hi_in = ddiff[31:0];
                  lo_in = {lo_ff[30:0], 1'b1};
               end else begin
                  hi_in = dt[31:0];
                  lo_in = {lo_ff[30:0], 1'b0};
               end
            end else begin
               hi_in = msum[32:1];
               lo_in = {msum[0], lo_ff[31:1]};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = M_FIX;
            end
         end
         M_FIX: begin
            case (f3_ff)
               3'd0:       res_in = prodn[31:0];
               3'd1, 3'd2, 3'd3: res_in = prodn[63:32];
               3'd4, 3'd5: res_in = bz_ff ? 32'hFFFF_FFFF :
                                    ((na_ff ^ nb_ff) ? (32'd0 - lo_ff) : lo_ff);
               default:    res_in = bz_ff ? a_ff : (na_ff ? (32'd0 - hi_ff) : hi_ff);
            endcase
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in; lo_ff <= lo_in; mag_ff <= mag_in; a_ff <= a_in;
      f3_ff <= f3_in; na_ff <= na_in; nb_ff <= nb_in; bz_ff <= bz_in;
      cnt_ff <= cnt_in; res_ff <= res_in;
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;
endmodule
`default_nettype wire

@@ sv/rv32im_hart_step.sv @@
// Top level: multicycle RV32IM hart with byte memory, register file and CSR store.
// Store-word transaction: four byte writes on the single memory port.
// Instruction: 4-byte fetch, 2 register-file reads, execute, retire; loads and stores add
// byte accesses, CSR ops and mret CSR read and write states, mul/div the iterative unit.
// One transaction at a time; the byte-wide memory port sets fetch and access time.
// Reset (synchronous) starts a clear of the whole CSR store and register file, req_stall high.
`default_nettype none
module rv32im_hart_step import rvh_pkg::*; #(
   parameter int MEMORY_BYTES = 65536
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_data,
   input  wire          csr_we,
   input  wire  [31:0]  csr_wdata
);
   localparam int MEM_AW = $clog2(MEMORY_BYTES);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MRD, S_MWR, S_RDA, S_RDB, S_EXEC,
      S_MDW, S_LDW, S_CSRR, S_CSRW, S_FIN
   } state_type;

   state_type   state_ff, state_in;
   logic [CSR_AW-1:0] clr_ff, clr_in;
   logic [31:0] base_ff, base_in, pc_ff, pc_in, npc_ff, npc_in;
   logic [31:0] ins_ff, ins_in, buf_ff, buf_in, off_ff, off_in, st_ff, st_in;
   logic [31:0] a_ff, a_in, wbv_ff, wbv_in;
   logic [2:0]  cnt_ff, cnt_in, n_ff, n_in;
   logic        fetch_ff, fetch_in, op_ff, op_in, wbe_ff, wbe_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [6:0]  opc, f7;
   logic [4:0]  rd, rs1, rs2;
   logic [2:0]  f3;
   logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, rb, alu_b, old, src;
   logic        take, shift_op, is_mret, accept;
   logic [1:0]  bidx;

   logic              mem_we;
   logic [MEM_AW-1:0] mem_addr;
   logic [7:0]        mem_wdata, mem_rdata;
   logic              rf_we;
   logic [4:0]        rf_waddr, rf_raddr;
   logic [31:0]       rf_wdata, rf_rdata;
   logic              cst_we;
   logic [CSR_AW-1:0] cst_waddr, cst_raddr;
   logic [31:0]       cst_wdata, cst_rdata;
   logic [11:0]       sys_idx;
   mdu_req_type       mreq;
   mdu_rsp_type       mrsp;

   function automatic logic [31:0] alu(input logic [2:0] fn, input logic alt,
                                       input logic [31:0] x, input logic [31:0] y);
      logic [31:0] r;
      begin
         case (fn)
            3'd0:    r = alt ? (x - y) : (x + y);
            3'd1:    r = x << y[4:0];
            3'd2:    r = {31'd0, $signed(x) < $signed(y)};
            3'd3:    r = {31'd0, x < y};
            3'd4:    r = x ^ y;
            3'd5:    r = alt ? 32'($signed(x) >>> y[4:0]) : (x >> y[4:0]);
            3'd6:    r = x | y;
            default: r = x & y;
         endcase
         return r;
      end
   endfunction

   rvh_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
      .clock(clock), .we(mem_we), .waddr(mem_addr), .wdata(mem_wdata),
      .raddr(mem_addr), .rdata(mem_rdata)
   );
   rvh_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
      .clock(clock), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
      .raddr(rf_raddr), .rdata(rf_rdata)
   );
   rvh_ram #(.WIDTH(32), .DEPTH(CSR_ENTRIES)) u_cst (
      .clock(clock), .we(cst_we), .waddr(cst_waddr), .wdata(cst_wdata),
      .raddr(cst_raddr), .rdata(cst_rdata)
   );
   rvh_mdu u_mdu (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   always_comb begin
      opc = ins_ff[6:0];
      rd  = ins_ff[11:7];
      f3  = ins_ff[14:12];
      rs1 = ins_ff[19:15];
      rs2 = ins_ff[24:20];
      f7  = ins_ff[31:25];
      imm_i = {{20{ins_ff[31]}}, ins_ff[31:20]};
      imm_s = {{20{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
      imm_b = {{19{ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25], ins_ff[11:8], 1'b0};
      imm_u = {ins_ff[31:12], 12'd0};
      imm_j = {{11{ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20],
               ins_ff[30:21], 1'b0};
      is_mret  = (ins_ff == INSN_MRET);
      sys_idx  = is_mret ? EPC_ADDR : ins_ff[31:20];
      rb       = rf_rdata;
      shift_op = (f3 == 3'd1) || (f3 == 3'd5);
      alu_b    = shift_op ? {27'd0, rs2} : imm_i;
      old      = (sys_idx == HARTID_ADDR) ? 32'd0 : cst_rdata;
      src      = f3[2] ? {27'd0, rs1} : a_ff;
      accept   = req_valid && !req_stall;
      bidx     = 2'(cnt_ff - 3'd1);

      case (f3)
         3'd0:    take = (a_ff == rb);
         3'd1:    take = (a_ff != rb);
         3'd4:    take = $signed(a_ff) < $signed(rb);
         3'd5:    take = $signed(a_ff) >= $signed(rb);
         3'd6:    take = a_ff < rb;
         3'd7:    take = a_ff >= rb;
         default: take = 1'b0;
      endcase

      state_in = state_ff; clr_in = clr_ff; base_in = base_ff; pc_in = pc_ff;
      npc_in = npc_ff; ins_in = ins_ff; buf_in = buf_ff; off_in = off_ff;
      st_in = st_ff; a_in = a_ff; wbv_in = wbv_ff; cnt_in = cnt_ff;
      n_in = n_ff; fetch_in = fetch_ff; op_in = op_ff; wbe_in = wbe_ff;
      status_in = status_ff; rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      mem_we = 1'b0;
      mem_addr = off_ff[MEM_AW-1:0] + MEM_AW'(cnt_ff);
      mem_wdata = st_ff[8*cnt_ff[1:0] +: 8];
      rf_we = 1'b0; rf_waddr = rd; rf_wdata = wbv_ff;
      rf_raddr = (state_ff == S_RDA) ? rs1 : rs2;
      cst_we = 1'b0; cst_waddr = sys_idx; cst_wdata = 32'd0; cst_raddr = sys_idx;
      mreq.start = 1'b0; mreq.funct3 = f3; mreq.a = a_ff; mreq.b = rb;

      if (csr_we) begin
         base_in = csr_wdata;
      end

      case (state_ff)
         S_CLEAR: begin
            cst_we = 1'b1;
            cst_waddr = clr_ff;
            rf_we = (clr_ff < CSR_AW'(32));
            rf_waddr = clr_ff[4:0];
            rf_wdata = 32'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == {CSR_AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in = req_data.op;
               wbe_in = 1'b0;
               wbv_in = 32'd0;
               npc_in = pc_ff;
               cnt_in = 3'd0;
               n_in = 3'd4;
               if (req_data.op == ITEM_STORE) begin
                  off_in = req_data.load_address - base_ff;
                  st_in = req_data.load_data;
                  status_in = ST_LOADED;
                  state_in = S_MWR;
               end else begin
                  off_in = pc_ff - base_ff;
                  fetch_in = 1'b1;
                  status_in = ST_EXEC;
                  state_in = S_MRD;
               end
            end
         end
         S_MRD: begin
            if (cnt_ff != 3'd0) begin
               if (fetch_ff) ins_in[8*bidx +: 8] = mem_rdata;
               else buf_in[8*bidx +: 8] = mem_rdata;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == n_ff) begin
               state_in = fetch_ff ? S_RDA : S_LDW;
            end
         end
         S_MWR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == n_ff - 3'd1) begin
               state_in = S_FIN;
            end
         end
         S_RDA: state_in = S_RDB;
         S_RDB: begin
            a_in = rf_rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            npc_in = pc_ff + 32'd4;
            state_in = S_FIN;
            fetch_in = 1'b0;
            cnt_in = 3'd0;
            case (opc)
               OPC_OP: begin
                  if (f7 == F7_MULDIV) begin
                     mreq.start = 1'b1;
                     state_in = S_MDW;
                  end else begin
                     wbe_in = (rd != 5'd0);
                     wbv_in = alu(f3, f7 == F7_ALT, a_ff, rb);
                  end
               end
               OPC_OPIMM: begin
                  wbe_in = (rd != 5'd0);
                  wbv_in = alu(f3, shift_op && (f7 == F7_ALT), a_ff, alu_b);
               end
               OPC_LOAD: begin
                  off_in = a_ff + imm_i - base_ff;
                  case (f3)
                     3'd0, 3'd4: begin n_in = 3'd1; state_in = S_MRD; end
                     3'd1, 3'd5: begin n_in = 3'd2; state_in = S_MRD; end
                     3'd2:       begin n_in = 3'd4; state_in = S_MRD; end
                     default:    state_in = S_FIN;
                  endcase
               end
               OPC_STORE: begin
                  off_in = a_ff + imm_s - base_ff;
                  st_in = rb;
                  case (f3)
                     3'd0:    begin n_in = 3'd1; state_in = S_MWR; end
                     3'd1:    begin n_in = 3'd2; state_in = S_MWR; end
                     3'd2:    begin n_in = 3'd4; state_in = S_MWR; end
                     default: state_in = S_FIN;
                  endcase
               end
               OPC_BRANCH: begin
                  if (take) npc_in = pc_ff + imm_b;
               end
               OPC_JAL: begin
                  wbe_in = (rd != 5'd0);
                  wbv_in = pc_ff + 32'd4;
                  npc_in = pc_ff + imm_j;
               end
               OPC_JALR: begin
                  wbe_in = (rd != 5'd0);
                  wbv_in = pc_ff + 32'd4;
                  npc_in = (a_ff + imm_i) & ~32'd1;
               end
               OPC_LUI: begin
                  wbe_in = (rd != 5'd0);
                  wbv_in = imm_u;
               end
               OPC_AUIPC: begin
                  wbe_in = (rd != 5'd0);
                  wbv_in = pc_ff + imm_u;
               end
               OPC_FENCE: ;
               OPC_SYSTEM: begin
                  if (f3 == 3'd0) begin
                     if (ins_ff == INSN_ECALL) status_in = ST_ECALL;
                     else if (is_mret) state_in = S_CSRR;
                  end else if (f3 != 3'd4) begin
                     state_in = S_CSRR;
                  end
               end
               default: status_in = ST_UNKNOWN;
            endcase
         end
         S_MDW: begin
            if (mrsp.done) begin
               wbe_in = (rd != 5'd0);
               wbv_in = mrsp.result;
               state_in = S_FIN;
            end
         end
         S_LDW: begin
            wbe_in = (rd != 5'd0);
            case (f3)
               3'd0:    wbv_in = {{24{buf_ff[7]}}, buf_ff[7:0]};
               3'd1:    wbv_in = {{16{buf_ff[15]}}, buf_ff[15:0]};
               3'd4:    wbv_in = {24'd0, buf_ff[7:0]};
               3'd5:    wbv_in = {16'd0, buf_ff[15:0]};
               default: wbv_in = buf_ff;
            endcase
            state_in = S_FIN;
         end
         S_CSRR: state_in = S_CSRW;
         S_CSRW: begin
            if (is_mret) begin
               npc_in = old;
            end else begin
               wbe_in = (rd != 5'd0);
               wbv_in = old;
               cst_we = ((f3[1:0] == 2'd1) || (rs1 != 5'd0)) && (sys_idx != HARTID_ADDR);
               case (f3[1:0])
                  2'd1:    cst_wdata = src;
                  2'd2:    cst_wdata = old | src;
                  default: cst_wdata = old & ~src;
               endcase
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rf_we = wbe_ff;
               pc_in = npc_ff;
               rsp_valid_in = 1'b1;
               rsp_in.next_pc = npc_ff;
               rsp_in.executed_instruction = op_ff ? ins_ff : 32'd0;
               rsp_in.status = status_ff;
               rsp_in.dest_written = wbe_ff;
               rsp_in.dest_index = wbe_ff ? rd : 5'd0;
               rsp_in.dest_value = wbe_ff ? wbv_ff : 32'd0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      npc_ff <= npc_in; ins_ff <= ins_in; buf_ff <= buf_in; off_ff <= off_in;
      st_ff <= st_in; a_ff <= a_in; wbv_ff <= wbv_in;
      cnt_ff <= cnt_in; n_ff <= n_in; fetch_ff <= fetch_in; op_ff <= op_in;
      wbe_ff <= wbe_in; status_ff <= status_in; rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         base_ff <= 32'd0;
         pc_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         base_ff <= base_in;
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

@@ sv/rvh_checker.sv @@
// Port-level checker for the hart and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module rvh_checker import rvh_pkg::*; (
   input wire     clock,
   input wire     reset,
   input wire     req_valid,
   input wire     req_stall,
   input req_type req_data,
   input wire     rsp_valid,
   input wire     rsp_stall,
   input rsp_type rsp_data
);
   `RVH_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> req_stall)
   `RVH_ASSERT(a_busy_after_accept, clock, reset,
      (req_valid && !req_stall && req_data.op == ITEM_STORE) |=> req_stall)
   `RVH_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
   `RVH_ASSERT(a_store_no_insn, clock, reset,
      (rsp_valid && rsp_data.status == ST_LOADED) |->
      (rsp_data.executed_instruction == 32'd0 && !rsp_data.dest_written))
   `RVH_ASSERT(a_no_dest_zero, clock, reset,
      (rsp_valid && !rsp_data.dest_written) |->
      (rsp_data.dest_index == 5'd0 && rsp_data.dest_value == 32'd0))
endmodule

bind rv32im_hart_step rvh_checker u_rvh_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);
`default_nettype wire
